// File: rtl/nrcc_pkg.sv
`default_nettype none

package nrcc_pkg;

  // Field widths fixed by the item format
  localparam int COLOR_W     = 8;
  localparam int CLASS_W     = 4;
  localparam int DIST_W      = 18;
  localparam int SQUARE_W    = 2 * COLOR_W;
  localparam int INDEX_W     = 5;
  localparam int IN_USE_W    = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = DIST_W;
  localparam int ENTRY_W     = 3 * COLOR_W + CLASS_W;

  // Defaults and reset values
  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam logic [DIST_W-1:0]   THRESHOLD_RESET   = 18'd700;
  localparam logic [IN_USE_W-1:0] IN_USE_RESET      = 6'd24;
  localparam logic [DIST_W-1:0]   NO_MATCH_DISTANCE = '1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Opcodes of an input item
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_USE    = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_CLASSIFY
  } cmd_kind_t;

  // One decoded item: a table load or a sample to classify
  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [CLASS_W-1:0] tag;
  } cmd_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } queue_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/nrcc_front.sv
`default_nettype none

module nrcc_front #(
  parameter int TABLE_DEPTH = nrcc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire  [nrcc_pkg::INDEX_W-1:0]       entry_index,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       ref_red,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       ref_green,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       ref_blue,
  input  wire  [nrcc_pkg::CLASS_W-1:0]       ref_class,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       sample_red,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       sample_green,
  input  wire  [nrcc_pkg::COLOR_W-1:0]       sample_blue,
  input  wire                                q_full,
  output logic                               push,
  output nrcc_pkg::cmd_t                     push_cmd
);

  logic           hold_valid;
  logic           hold_valid_next;
  nrcc_pkg::cmd_t hold;
  nrcc_pkg::cmd_t decoded;
  logic           accept;
  logic           keep;

  // Stall only when the holding stage is full and cannot drain
  assign busy   = hold_valid & q_full;
  assign accept = start & ~busy;
  assign push   = hold_valid & ~q_full;

  // Decode the item; drop loads that fall outside the table
  always_comb begin
    decoded = '0;
    if (opcode == nrcc_pkg::OP_LOAD) begin
      decoded.kind  = nrcc_pkg::CMD_LOAD;
      decoded.index = entry_index;
      decoded.red   = ref_red;
      decoded.green = ref_green;
      decoded.blue  = ref_blue;
      decoded.tag   = ref_class;
      keep          = (32'(entry_index) < TABLE_DEPTH);
    end else begin
      decoded.kind  = nrcc_pkg::CMD_CLASSIFY;
      decoded.red   = sample_red;
      decoded.green = sample_green;
      decoded.blue  = sample_blue;
      keep          = 1'b1;
    end
  end

  assign hold_valid_next = accept ? keep : (hold_valid & q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // Capture a new item whenever one is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

  assign push_cmd = hold;

endmodule

`default_nettype wire

// File: rtl/nrcc_queue.sv
`default_nettype none

module nrcc_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  nrcc_pkg::cmd_t        push_cmd,
  output logic                  full,
  input  wire                   pop,
  output nrcc_pkg::queue_out_t  q_out
);

  nrcc_pkg::cmd_t                slots [nrcc_pkg::QUEUE_DEPTH];
  logic [nrcc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [nrcc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [nrcc_pkg::QUEUE_AW:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == (nrcc_pkg::QUEUE_AW + 1)'(nrcc_pkg::QUEUE_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & (count != '0);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the item at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign q_out.empty = (count == '0);
  assign q_out.head  = slots[rd_ptr];

endmodule

`default_nettype wire

// File: rtl/nrcc_back.sv
`default_nettype none

module nrcc_back #(
  parameter int TABLE_DEPTH = nrcc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  nrcc_pkg::queue_out_t              q_out,
  output logic                              pop,
  input  wire  [nrcc_pkg::DIST_W-1:0]       distance_threshold,
  input  wire  [nrcc_pkg::IN_USE_W-1:0]     entries_in_use,
  output logic                              done,
  output logic                              matched,
  output logic [nrcc_pkg::CLASS_W-1:0]      match_class,
  output logic [nrcc_pkg::DIST_W-1:0]       best_distance
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > nrcc_pkg::IN_USE_W) ? CW : nrcc_pkg::IN_USE_W;
  localparam int CL = nrcc_pkg::COLOR_W;
  localparam int TW = nrcc_pkg::CLASS_W;
  localparam int SW = nrcc_pkg::SQUARE_W;
  localparam int DW = nrcc_pkg::DIST_W;

  function automatic logic [CL-1:0] abs_diff(input logic [CL-1:0] a, input logic [CL-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  nrcc_pkg::back_state_t state;
  nrcc_pkg::back_state_t state_next;

  logic [nrcc_pkg::ENTRY_W-1:0] ref_mem [TABLE_DEPTH];
  logic [nrcc_pkg::ENTRY_W-1:0] rd_q;

  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] lim;
  logic [CW-1:0] lim_now;
  logic [EW-1:0] in_use_ext;
  logic          mem_we;
  logic          issue;
  logic          issue_last;
  logic          start_scan;

  logic [CL-1:0] smp_r;
  logic [CL-1:0] smp_g;
  logic [CL-1:0] smp_b;

  logic          p0_valid;
  logic          p0_last;
  logic          p1_valid;
  logic          p1_last;
  logic [SW-1:0] sq_r;
  logic [SW-1:0] sq_g;
  logic [SW-1:0] sq_b;
  logic [TW-1:0] tag1;
  logic          p2_valid;
  logic          p2_last;
  logic [DW-1:0] dist2;
  logic [TW-1:0] tag2;

  logic          found;
  logic [DW-1:0] best;
  logic [TW-1:0] best_tag;
  logic [CL-1:0] d_r;
  logic [CL-1:0] d_g;
  logic [CL-1:0] d_b;

  // Clamp the searched count to the table depth
  assign in_use_ext = EW'(entries_in_use);
  assign lim_now    = (in_use_ext > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(in_use_ext);
  assign issue_last = (idx == lim - CW'(1));

  // Sequence loads and table walks
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    start_scan = 1'b0;
    case (state)
      nrcc_pkg::ST_IDLE: begin
        if (!q_out.empty) begin
          pop = 1'b1;
          if (q_out.head.kind == nrcc_pkg::CMD_LOAD) begin
            mem_we = 1'b1;
          end else begin
            start_scan = 1'b1;
            idx_next   = '0;
            state_next = (lim_now == '0) ? nrcc_pkg::ST_FINISH : nrcc_pkg::ST_SCAN;
          end
        end
      end
      nrcc_pkg::ST_SCAN: begin
        issue    = 1'b1;
        idx_next = idx + CW'(1);
        if (issue_last) begin
          state_next = nrcc_pkg::ST_DRAIN;
        end
      end
      nrcc_pkg::ST_DRAIN: begin
        if (p2_valid && p2_last) begin
          state_next = nrcc_pkg::ST_FINISH;
        end
      end
      nrcc_pkg::ST_FINISH: begin
        state_next = nrcc_pkg::ST_IDLE;
      end
      default: begin
        state_next = nrcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nrcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold scan counter, limit and sample
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (start_scan) begin
      lim   <= lim_now;
      smp_r <= q_out.head.red;
      smp_g <= q_out.head.green;
      smp_b <= q_out.head.blue;
    end
  end

  // Reference table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[AW'(q_out.head.index)] <= {q_out.head.red, q_out.head.green,
                                         q_out.head.blue, q_out.head.tag};
    end
    if (issue) begin
      rd_q <= ref_mem[idx[AW-1:0]];
    end
  end

  // Pipeline valid and last flags
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
      p0_last  <= 1'b0;
      p1_valid <= 1'b0;
      p1_last  <= 1'b0;
      p2_valid <= 1'b0;
      p2_last  <= 1'b0;
    end else begin
      p0_valid <= issue;
      p0_last  <= issue & issue_last;
      p1_valid <= p0_valid;
      p1_last  <= p0_last;
      p2_valid <= p1_valid;
      p2_last  <= p1_last;
    end
  end

  assign d_r = abs_diff(smp_r, rd_q[nrcc_pkg::ENTRY_W-1 -: CL]);
  assign d_g = abs_diff(smp_g, rd_q[TW + 2*CL-1 -: CL]);
  assign d_b = abs_diff(smp_b, rd_q[TW + CL-1 -: CL]);

  // Square each component difference, then sum
  always_ff @(posedge clk) begin
    sq_r  <= {{(SW-CL){1'b0}}, d_r} * {{(SW-CL){1'b0}}, d_r};
    sq_g  <= {{(SW-CL){1'b0}}, d_g} * {{(SW-CL){1'b0}}, d_g};
    sq_b  <= {{(SW-CL){1'b0}}, d_b} * {{(SW-CL){1'b0}}, d_b};
    tag1  <= rd_q[TW-1:0];
    dist2 <= DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
    tag2  <= tag1;
  end

  // Keep the nearest entry within the threshold; lower index wins ties
  always_ff @(posedge clk) begin
    if (start_scan) begin
      found    <= 1'b0;
      best     <= nrcc_pkg::NO_MATCH_DISTANCE;
      best_tag <= '0;
    end else if (p2_valid && (dist2 <= distance_threshold) && (!found || (dist2 < best))) begin
      found    <= 1'b1;
      best     <= dist2;
      best_tag <= tag2;
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == nrcc_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == nrcc_pkg::ST_FINISH) begin
      matched       <= found;
      match_class   <= found ? best_tag : '0;
      best_distance <= found ? best : nrcc_pkg::NO_MATCH_DISTANCE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nearest_reference_color_classifier_core.sv
// Nearest reference color classifier.
// Input channel: an item is taken at a rising edge with start high and busy
// low. opcode selects a table load (entry_index, ref_red/green/blue,
// ref_class) or a classification of sample_red/green/blue. Loads with an
// index beyond the table are dropped and give no result.
// Result channel: done is high for one cycle with matched, match_class and
// best_distance; the receiver has no way to stall it. No match reports
// class 0 and distance all ones.
// Configuration: cfg_write with cfg_index and cfg_data sets the distance
// threshold (index 0) or the number of entries searched (index 1); write
// only while no item is in flight.
// Timing: a four-deep queue separates the input stage from the search
// engine. A classify walks N = min(entries in use, TABLE_DEPTH) entries at
// one table read per cycle through a registered read, a squaring stage and
// a sum stage (no walk and no match when N is 0); the engine pops the next
// queued item, load or classify, only once it is idle again. busy rises
// only while the queue is full.
// Reset: clears queue, engine and result strobe and restores the register
// defaults; table contents stay undefined until loaded.
`default_nettype none

module nearest_reference_color_classifier_core #(
  parameter int TABLE_DEPTH = nrcc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   opcode,
  input  wire  [nrcc_pkg::INDEX_W-1:0]          entry_index,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          ref_red,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          ref_green,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          ref_blue,
  input  wire  [nrcc_pkg::CLASS_W-1:0]          ref_class,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          sample_red,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          sample_green,
  input  wire  [nrcc_pkg::COLOR_W-1:0]          sample_blue,
  input  wire                                   cfg_write,
  input  wire  [nrcc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [nrcc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  done,
  output logic                                  matched,
  output logic [nrcc_pkg::CLASS_W-1:0]          match_class,
  output logic [nrcc_pkg::DIST_W-1:0]           best_distance
);

  logic [nrcc_pkg::DIST_W-1:0]   distance_threshold;
  logic [nrcc_pkg::IN_USE_W-1:0] entries_in_use;
  logic                          q_full;
  logic                          push;
  logic                          pop;
  nrcc_pkg::cmd_t                push_cmd;
  nrcc_pkg::queue_out_t          q_out;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_threshold <= nrcc_pkg::THRESHOLD_RESET;
      entries_in_use     <= nrcc_pkg::IN_USE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nrcc_pkg::REG_THRESHOLD: distance_threshold <= cfg_data;
        nrcc_pkg::REG_IN_USE:    entries_in_use <= nrcc_pkg::IN_USE_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  nrcc_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .ref_red      (ref_red),
    .ref_green    (ref_green),
    .ref_blue     (ref_blue),
    .ref_class    (ref_class),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  nrcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_out    (q_out)
  );

  nrcc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_out              (q_out),
    .pop                (pop),
    .distance_threshold (distance_threshold),
    .entries_in_use     (entries_in_use),
    .done               (done),
    .matched            (matched),
    .match_class        (match_class),
    .best_distance      (best_distance)
  );

endmodule

`default_nettype wire

// File: rtl/nrcc_checker.sv
`default_nettype none

module nrcc_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              busy,
  input wire                              done,
  input wire                              matched,
  input wire [nrcc_pkg::CLASS_W-1:0]      match_class,
  input wire [nrcc_pkg::DIST_W-1:0]       best_distance
);

  // Reset leaves the block empty and quiet
  assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or done after reset");

  // done is a one-cycle strobe: it is never high in consecutive cycles
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // A miss reports class zero and the all-ones distance
  assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (match_class == '0 &&
                            best_distance == nrcc_pkg::NO_MATCH_DISTANCE))
    else $error("no-match result has wrong payload");

  // A hit always carries a real distance
  assert property (@(posedge clk) disable iff (rst)
    (done && matched) |-> (best_distance != nrcc_pkg::NO_MATCH_DISTANCE))
    else $error("match reported with no-match distance");

endmodule

bind nearest_reference_color_classifier_core nrcc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .matched       (matched),
  .match_class   (match_class),
  .best_distance (best_distance)
);

`default_nettype wire
